// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the reconstruction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLMR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PLMR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define PLMR_ASSERT(lbl, clk, rst_n, prop)
`define PLMR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/plmr_pkg.sv =====
// Shared types and constants of the limited face reconstruction block.
package plmr_pkg;

  localparam int VAL_W   = 32;
  localparam int MAG_W   = VAL_W + 1;
  localparam int CF_W    = 20;
  localparam int FR_W    = 17;
  localparam int FACE_SH = 16;
  localparam int COEF_SH = 16;
  localparam int AB_W    = 2 * MAG_W - 1;
  localparam int MY_W    = 53;
  localparam int NUM_W   = 120;
  localparam int DEN_W   = 88;
  localparam int CNT_W   = 5;

  typedef struct packed {
    logic [MAG_W-1:0] mag_l;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] mag_diff;
    logic             neg;
    logic             agree;
    logic [VAL_W-1:0] mid;
    logic [CF_W-1:0]  cf;
    logic [CF_W-1:0]  cb;
    logic [FR_W-1:0]  fu;
    logic [FR_W-1:0]  fl;
    logic             last;
  } job_t;

endpackage

// ===== hw/rtl/plm_limited_face_reconstruct.sv =====
// Top level of the limited piecewise linear face reconstruction block.
// A flat cell (disagreeing slopes) goes straight to the face values, a van Leer cell
// takes one product and a division, a Mignone cell a chain of products and a division.
// The back part takes a new word only when idle; the shared shift-add multiplier (one
// multiplier bit per cycle) and radix-2 divider (one quotient bit per cycle) pace it.
// The front accepts words every cycle while the two-entry queue has room.
// Reset is asynchronous and active low; it empties the window, queue and result.
module plm_limited_face_reconstruct (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [plmr_pkg::VAL_W-1:0] cell_value_i,
  input  logic [plmr_pkg::CF_W-1:0]         coeff_forward_i,
  input  logic [plmr_pkg::CF_W-1:0]         coeff_backward_i,
  input  logic [plmr_pkg::FR_W-1:0]         frac_upper_i,
  input  logic [plmr_pkg::FR_W-1:0]         frac_lower_i,
  input  logic                              row_end_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [plmr_pkg::VAL_W-1:0] face_upper_value_o,
  output logic signed [plmr_pkg::VAL_W-1:0] face_lower_value_o,
  output logic                              saturated_o,
  output logic                              last_of_row_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i
);

  logic           q_wr, q_full, q_valid, q_rd;
  plmr_pkg::job_t wr_job, rd_job;

  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  plmr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .q_full_i         (q_full),
    .cell_value_i     (cell_value_i),
    .coeff_forward_i  (coeff_forward_i),
    .coeff_backward_i (coeff_backward_i),
    .frac_upper_i     (frac_upper_i),
    .frac_lower_i     (frac_lower_i),
    .row_end_i        (row_end_i),
    .q_wr_o           (q_wr),
    .q_job_o          (wr_job)
  );

  plmr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_job_i (wr_job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_job_o (rd_job)
  );

  plmr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (q_valid),
    .job_i              (rd_job),
    .job_pop_o          (q_rd),
    .cfg_wr_i           (cfg_valid_i && cfg_ready_o),
    .cfg_mode_i         (cfg_data_i),
    .pop                (pop),
    .empty              (empty),
    .face_upper_value_o (face_upper_value_o),
    .face_lower_value_o (face_lower_value_o),
    .saturated_o        (saturated_o),
    .last_of_row_o      (last_of_row_o)
  );

endmodule

// ===== hw/rtl/plmr_front.sv =====
// Front part: cell window, differences and classification of each word.
module plmr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  input  logic                         q_full_i,
  input  logic signed [plmr_pkg::VAL_W-1:0] cell_value_i,
  input  logic [plmr_pkg::CF_W-1:0]    coeff_forward_i,
  input  logic [plmr_pkg::CF_W-1:0]    coeff_backward_i,
  input  logic [plmr_pkg::FR_W-1:0]    frac_upper_i,
  input  logic [plmr_pkg::FR_W-1:0]    frac_lower_i,
  input  logic                         row_end_i,
  output logic                         q_wr_o,
  output plmr_pkg::job_t               q_job_o
);

  logic [plmr_pkg::VAL_W-1:0] older_q, older_d, mid_q, mid_d;
  logic [plmr_pkg::CF_W-1:0]  cf_q, cf_d, cb_q, cb_d;
  logic [plmr_pkg::FR_W-1:0]  fu_q, fu_d, fl_q, fl_d;
  logic [1:0]                 fill_q, fill_d;
  logic                       acc;
  logic [plmr_pkg::MAG_W-1:0] dl, dr, ma, mb;

  assign acc = push && !q_full_i;
  assign dl  = {mid_q[plmr_pkg::VAL_W-1], mid_q} - {older_q[plmr_pkg::VAL_W-1], older_q};
  assign dr  = {cell_value_i[plmr_pkg::VAL_W-1], cell_value_i}
             - {mid_q[plmr_pkg::VAL_W-1], mid_q};
  assign ma  = dl[plmr_pkg::MAG_W-1] ? -dl : dl;
  assign mb  = dr[plmr_pkg::MAG_W-1] ? -dr : dr;

  always_comb begin
    q_job_o.mag_l    = ma;
    q_job_o.mag_r    = mb;
    q_job_o.mag_diff = (ma >= mb) ? ma - mb : mb - ma;
    q_job_o.neg      = dl[plmr_pkg::MAG_W-1];
    q_job_o.agree    = (dl != '0) && (dr != '0)
                     && (dl[plmr_pkg::MAG_W-1] == dr[plmr_pkg::MAG_W-1]);
    q_job_o.mid      = mid_q;
    q_job_o.cf       = cf_q;
    q_job_o.cb       = cb_q;
    q_job_o.fu       = fu_q;
    q_job_o.fl       = fl_q;
    q_job_o.last     = row_end_i;
  end

  assign q_wr_o = acc && (fill_q == 2'd2);

  always_comb begin
    older_d = older_q;
    mid_d   = mid_q;
    cf_d    = cf_q;
    cb_d    = cb_q;
    fu_d    = fu_q;
    fl_d    = fl_q;
    fill_d  = fill_q;
    if (acc) begin
      older_d = mid_q;
      mid_d   = cell_value_i;
      cf_d    = coeff_forward_i;
      cb_d    = coeff_backward_i;
      fu_d    = frac_upper_i;
      fl_d    = frac_lower_i;
      if (fill_q != 2'd2) begin
        fill_d = fill_q + 2'd1;
      end
      if (row_end_i) begin
        fill_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      mid_q   <= '0;
      cf_q    <= '0;
      cb_q    <= '0;
      fu_q    <= '0;
      fl_q    <= '0;
      fill_q  <= '0;
    end else begin
      older_q <= older_d;
      mid_q   <= mid_d;
      cf_q    <= cf_d;
      cb_q    <= cb_d;
      fu_q    <= fu_d;
      fl_q    <= fl_d;
      fill_q  <= fill_d;
    end
  end

endmodule

// ===== hw/rtl/plmr_queue.sv =====
// Two-entry queue of classified words between the front and back parts.
`include "assert_macros.svh"
module plmr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  plmr_pkg::job_t wr_job_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output plmr_pkg::job_t rd_job_o
);

  plmr_pkg::job_t slot_q [2];
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o   = (cnt_q == 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign rd_job_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = !wptr_q;
    end
    if (rd_i) begin
      rptr_d = !rptr_q;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `PLMR_NEVER(a_no_overrun, clk_i, rst_ni, wr_i && full_o)
  `PLMR_NEVER(a_no_underrun, clk_i, rst_ni, rd_i && !valid_o)
  `PLMR_ASSERT(a_ptr_count, clk_i, rst_ni, (cnt_q == 2'd1) |-> (wptr_q != rptr_q))

endmodule

// ===== hw/rtl/plmr_back.sv =====
// Back part: limiter arithmetic, division, face values and result register.
`include "assert_macros.svh"
module plmr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  plmr_pkg::job_t              job_i,
  output logic                        job_pop_o,
  input  logic                        cfg_wr_i,
  input  logic                        cfg_mode_i,
  input  logic                        pop,
  output logic                        empty,
  output logic [plmr_pkg::VAL_W-1:0]  face_upper_value_o,
  output logic [plmr_pkg::VAL_W-1:0]  face_lower_value_o,
  output logic                        saturated_o,
  output logic                        last_of_row_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AB   = 4'd1;
  localparam logic [3:0] ST_CFA  = 4'd2;
  localparam logic [3:0] ST_CBB  = 4'd3;
  localparam logic [3:0] ST_NUM  = 4'd4;
  localparam logic [3:0] ST_D2   = 4'd5;
  localparam logic [3:0] ST_DEN  = 4'd6;
  localparam logic [3:0] ST_DCHK = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_FU   = 4'd9;
  localparam logic [3:0] ST_FL   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam int VW = plmr_pkg::VAL_W;
  localparam int NW = plmr_pkg::NUM_W;
  localparam int DW = plmr_pkg::DEN_W;
  localparam int YW = plmr_pkg::MY_W;

  logic [3:0]                state_q, state_d;
  plmr_pkg::job_t            job_q, job_d;
  logic                      mode_q, mode_d;
  logic [plmr_pkg::AB_W-1:0] ab_q, ab_d;
  logic [YW-1:0]             t_q, t_d, my_q, my_d, t_sum;
  logic [NW-1:0]             num_q, num_d, mx_q, mx_d, acc_q, acc_d;
  logic [DW-1:0]             den_q, den_d, rem_q, rem_d;
  logic [VW-1:0]             nsh_q, nsh_d, quo_q, quo_d;
  logic [plmr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      sat_q, sat_d;
  logic [VW-1:0]             up_q, up_d, lo_q, lo_d;
  logic                      outv_q, outv_d;
  logic [VW-1:0]             ou_q, ou_d, ol_q, ol_d;
  logic                      os_q, os_d, oe_q, oe_d;
  logic                      mul_busy;
  logic [DW:0]               r2;
  logic [plmr_pkg::FR_W-1:0] frac;
  logic [plmr_pkg::FR_W+VW-1:0] prod;
  logic [VW+2:0]             mid_x, term_x, fsum;
  logic                      add_term, ov_hi, ov_lo;
  logic [VW-1:0]             face;

  assign mul_busy = (my_q != '0);
  assign t_sum    = t_q + acc_q[YW-1:0];
  assign r2       = {rem_q, nsh_q[VW-1]};

  assign frac     = (state_q == ST_FU) ? job_q.fu : job_q.fl;
  assign prod     = frac * quo_q;
  assign add_term = (state_q == ST_FU) ? !job_q.neg : job_q.neg;
  assign mid_x    = {{3{job_q.mid[VW-1]}}, job_q.mid};
  assign term_x   = {2'b00, prod[plmr_pkg::FR_W+VW-1:plmr_pkg::FACE_SH]};
  assign fsum     = add_term ? mid_x + term_x : mid_x - term_x;
  assign ov_hi    = !fsum[VW+2] && (fsum[VW+2:VW-1] != 4'b0000);
  assign ov_lo    = fsum[VW+2] && (fsum[VW+2:VW-1] != 4'b1111);

  always_comb begin
    face = fsum[VW-1:0];
    if (ov_hi) begin
      face = {1'b0, {(VW-1){1'b1}}};
    end else if (ov_lo) begin
      face = {1'b1, {(VW-1){1'b0}}};
    end
  end

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    mode_d  = cfg_wr_i ? cfg_mode_i : mode_q;
    ab_d    = ab_q;
    t_d     = t_q;
    num_d   = num_q;
    den_d   = den_q;
    mx_d    = mx_q;
    my_d    = my_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    nsh_d   = nsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    up_d    = up_q;
    lo_d    = lo_q;
    outv_d  = outv_q;
    ou_d    = ou_q;
    ol_d    = ol_q;
    os_d    = os_q;
    oe_d    = oe_q;

    if (pop && outv_q) begin
      outv_d = 1'b0;
    end

    if ((state_q >= ST_AB) && (state_q <= ST_DEN) && mul_busy) begin
      acc_d = my_q[0] ? acc_q + mx_q : acc_q;
      mx_d  = mx_q << 1;
      my_d  = my_q >> 1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_d = job_i;
            sat_d = 1'b0;
            quo_d = '0;
            acc_d = '0;
            if (job_i.agree) begin
              mx_d    = NW'(job_i.mag_l);
              my_d    = YW'(job_i.mag_r);
              state_d = ST_AB;
            end else begin
              state_d = ST_FU;
            end
          end
        end
        ST_AB: begin
          ab_d  = acc_q[plmr_pkg::AB_W-1:0];
          acc_d = '0;
          if (!mode_q) begin
            num_d   = acc_q << 1;
            den_d   = DW'(job_q.mag_l) + DW'(job_q.mag_r);
            state_d = ST_DCHK;
          end else begin
            mx_d    = NW'(job_q.mag_l);
            my_d    = YW'(job_q.cf);
            state_d = ST_CFA;
          end
        end
        ST_CFA: begin
          t_d     = acc_q[YW-1:0];
          acc_d   = '0;
          mx_d    = NW'(job_q.mag_r);
          my_d    = YW'(job_q.cb);
          state_d = ST_CBB;
        end
        ST_CBB: begin
          acc_d   = '0;
          mx_d    = NW'(ab_q);
          my_d    = t_sum;
          state_d = ST_NUM;
        end
        ST_NUM: begin
          num_d   = acc_q;
          acc_d   = '0;
          mx_d    = NW'(job_q.mag_diff);
          my_d    = YW'(job_q.mag_diff);
          state_d = ST_D2;
        end
        ST_D2: begin
          den_d   = DW'(acc_q) << plmr_pkg::COEF_SH;
          acc_d   = '0;
          mx_d    = NW'(ab_q);
          my_d    = YW'({1'b0, job_q.cf} + {1'b0, job_q.cb});
          state_d = ST_DEN;
        end
        ST_DEN: begin
          den_d   = den_q + acc_q[DW-1:0];
          state_d = ST_DCHK;
        end
        ST_DCHK: begin
          if (den_q == '0) begin
            quo_d   = '0;
            state_d = ST_FU;
          end else if (num_q >= {den_q, {VW{1'b0}}}) begin
            quo_d   = '1;
            sat_d   = 1'b1;
            state_d = ST_FU;
          end else begin
            rem_d   = num_q[NW-1:VW];
            nsh_d   = num_q[VW-1:0];
            cnt_d   = '1;
            state_d = ST_DIV;
          end
        end
        ST_DIV: begin
          if (r2 >= {1'b0, den_q}) begin
            rem_d = DW'(r2 - {1'b0, den_q});
            quo_d = {quo_q[VW-2:0], 1'b1};
          end else begin
            rem_d = r2[DW-1:0];
            quo_d = {quo_q[VW-2:0], 1'b0};
          end
          nsh_d = nsh_q << 1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_FU;
          end
        end
        ST_FU: begin
          up_d    = face;
          sat_d   = sat_q || ov_hi || ov_lo;
          state_d = ST_FL;
        end
        ST_FL: begin
          lo_d    = face;
          sat_d   = sat_q || ov_hi || ov_lo;
          state_d = ST_OUT;
        end
        ST_OUT: begin
          if (!outv_q || pop) begin
            outv_d  = 1'b1;
            ou_d    = up_q;
            ol_d    = lo_q;
            os_d    = sat_q;
            oe_d    = job_q.last;
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    ab_q  <= ab_d;
    t_q   <= t_d;
    num_q <= num_d;
    den_q <= den_d;
    mx_q  <= mx_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    nsh_q <= nsh_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    sat_q <= sat_d;
    up_q  <= up_d;
    lo_q  <= lo_d;
    ou_q  <= ou_d;
    ol_q  <= ol_d;
    os_q  <= os_d;
    oe_q  <= oe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= 1'b0;
      my_q    <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      my_q    <= my_d;
      outv_q  <= outv_d;
    end
  end

  assign empty              = !outv_q;
  assign face_upper_value_o = ou_q;
  assign face_lower_value_o = ol_q;
  assign saturated_o        = os_q;
  assign last_of_row_o      = oe_q;

  `PLMR_ASSERT(a_div_den_nonzero, clk_i, rst_ni, (state_q == ST_DIV) |-> (den_q != '0))
  `PLMR_ASSERT(a_result_held, clk_i, rst_ni, (outv_q && !pop) |=> (outv_q && $stable(ou_q)))
  `PLMR_ASSERT(a_pop_only_idle, clk_i, rst_ni, job_pop_o |=> (state_q != ST_IDLE))

endmodule
